// ----- hw/rtl/bhcd_pkg.sv -----
package bhcd_pkg;

  localparam int MAX_BLOCKS_DEF   = 512;
  localparam int MAX_BLOCK_PIXELS = 4096;
  localparam int FIFO_DEPTH       = 2;

  localparam int HUE_SUM_W = 21;
  localparam int SV_SUM_W  = 19;
  localparam int BP_W      = 13;
  localparam int CP_W      = 8;

  localparam logic [7:0] MARK_RED   = 8'd100;
  localparam logic [7:0] MARK_GREEN = 8'd250;
  localparam logic [7:0] MARK_BLUE  = 8'd30;

  localparam logic [BP_W-1:0] BP_RESET = 13'd400;
  localparam logic [CP_W-1:0] CP_RESET = 8'd70;

  // register byte offsets within the config window
  localparam logic [2:0] REG_BLOCK_PIXELS   = 3'd0;
  localparam logic [2:0] REG_CHANGE_PERCENT = 3'd4;

  // one converted pixel on its way from the front to the back
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] block_index;
    logic       first;
    logic       last;
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] val;
  } pix_t;

endpackage

// ----- hw/rtl/block_hsv_change_detector.sv -----
// Block HSV change detector.
// Pixel channel: red/green/blue, block_index, first_in_block, last_in_block
// move on in_valid/in_ready; one result per pixel leaves on out_valid/out_ready
// with the pixel color (marked 100/250/30 while the block's stored change flag
// is set) and, on a block's last pixel, block_done with the block averages of
// hue, saturation and value and the new change flag.
// The front converts each pixel to HSV through two bit-serial dividers and
// takes no new pixel until the current one has run its 15-step hue/saturation
// divide and been pushed on. A two-entry queue separates it from the back,
// which takes one pixel at a time and updates the per-block sums in one
// memory; on a block close it runs the three average divides and the
// change-ratio divide through one shared 21-step divider, skipping the ratio
// divide when old and new value are both zero.
// A stalled receiver holds the result; the front keeps taking pixels until the
// queue is full and its own converted pixel waits, then in_ready stays low.
// After reset a clearing pass zeroes all MAX_BLOCKS entries of the per-block
// memory; no pixel is taken meanwhile, config writes are. The registers reset
// to block_pixels 400 and change_percent 70, at byte offsets 0 and 4.
module block_hsv_change_detector import bhcd_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [8:0]  block_index,
  input  logic        first_in_block,
  input  logic        last_in_block,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        block_done,
  output logic [8:0]  avg_hue,
  output logic [6:0]  avg_sat,
  output logic [6:0]  avg_val,
  output logic        changed,
  output logic        out_valid,
  input  logic        out_ready
);

  logic [BP_W-1:0] block_pixels;
  logic [CP_W-1:0] change_percent;
  logic            wr_en;
  logic            clearing;
  logic            push_valid, push_ready;
  pix_t            push_data;
  logic            q_valid, q_pop;
  pix_t            q_data;

  // config registers; low address bits select a byte lane and are ignored
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_pixels   <= BP_RESET;
      change_percent <= CP_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_CHANGE_PERCENT[2]) change_percent <= pwdata[CP_W-1:0];
      else block_pixels <= pwdata[BP_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CHANGE_PERCENT[2]) prdata = {24'd0, change_percent};
    else prdata = {19'd0, block_pixels};
  end

  // front: accept and convert; held off while the memory is being cleared
  bhcd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .hold           (clearing),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .block_index    (block_index),
    .first_in_block (first_in_block),
    .last_in_block  (last_in_block),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .push_ready     (push_ready)
  );

  bhcd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  // back: accumulate per block, close blocks, drive the result register
  bhcd_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .block_pixels   (block_pixels),
    .change_percent (change_percent),
    .fifo_valid     (q_valid),
    .fifo_data      (q_data),
    .fifo_pop       (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .block_done     (block_done),
    .avg_hue        (avg_hue),
    .avg_sat        (avg_sat),
    .avg_val        (avg_val),
    .changed        (changed)
  );

`ifndef NO_ASSERTIONS
  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("pixel taken during memory clear");

  a_changed_only_on_close: assert property (@(posedge clk) disable iff (rst)
    (out_valid && changed) |-> block_done)
    else $error("change flag without block close");

  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_done) |-> (avg_hue <= 9'd359 && avg_sat <= 7'd100 &&
                                   avg_val <= 7'd100))
    else $error("block average out of range");
`endif

endmodule

// ----- hw/rtl/bhcd_div.sv -----
module bhcd_div import bhcd_pkg::*; #(
  parameter int WN = 15,
  parameter int WD = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WN-1:0] dividend,
  input  logic [WD-1:0] divisor,
  output logic          done,
  output logic [WN-1:0] quotient,
  output logic [WD-1:0] remainder
);

  localparam int CW = $clog2(WN + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WN-1:0] quo;
  logic [WD-1:0] rem;
  logic [WD-1:0] dvs;
  logic [WD:0]   trial;
  logic [WD:0]   diff;
  logic          fits;

  // one restoring step per cycle, MSB first
  assign trial = {rem, quo[WN-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WN - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[WN-2:0], fits};
      rem <= fits ? diff[WD-1:0] : trial[WD-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- hw/rtl/bhcd_front.sv -----
module bhcd_front import bhcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       hold,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [8:0] block_index,
  input  logic       first_in_block,
  input  logic       last_in_block,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       push_valid,
  output pix_t       push_data,
  input  logic       push_ready
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;
  typedef enum logic [1:0] {MX_RED, MX_GREEN, MX_BLUE} mxsel_t;

  fstate_t state;
  pix_t    ent;
  mxsel_t  sel;
  logic    neg;
  logic    dz;
  logic    mz;

  logic [7:0]  mx, mn, d, a0;
  logic        neg_c;
  mxsel_t      sel_c;
  logic [14:0] vx;
  logic [6:0]  vq0;
  logic [8:0]  vr;
  logic [6:0]  v_c;
  logic        acc;

  logic        hdone, sdone;
  logic [14:0] hq, sq;
  logic [7:0]  hrem, srem;
  logic [8:0]  qh;
  logic [8:0]  hue_c;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state == F_IDLE) && !hold;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    d = mx - mn;
    // ties go to blue, then green
    priority if (blue == mx) begin
      sel_c = MX_BLUE;
      neg_c = green > red;
      a0    = neg_c ? green - red : red - green;
    end else if (green == mx) begin
      sel_c = MX_GREEN;
      neg_c = red > blue;
      a0    = neg_c ? red - blue : blue - red;
    end else begin
      sel_c = MX_RED;
      neg_c = blue > green;
      a0    = neg_c ? blue - green : green - blue;
    end
    // value = floor(100*mx/255) by shift and one correction
    vx  = 15'(mx) * 15'd100;
    vq0 = vx[14:8];
    vr  = {1'b0, vx[7:0]} + 9'(vq0);
    v_c = vq0 + 7'(vr >= 9'd255);
  end

  bhcd_div #(.WN(15), .WD(8)) u_hdiv (
    .clk       (clk),
    .rst       (rst),
    .start     (acc),
    .dividend  (15'(a0) * 15'd60),
    .divisor   (d),
    .done      (hdone),
    .quotient  (hq),
    .remainder (hrem)
  );

  bhcd_div #(.WN(15), .WD(8)) u_sdiv (
    .clk       (clk),
    .rst       (rst),
    .start     (acc),
    .dividend  (15'(d) * 15'd100),
    .divisor   (mx),
    .done      (sdone),
    .quotient  (sq),
    .remainder (srem)
  );

  assign qh = hq[8:0];

  // floor for the blue and green sectors, truncation for the red one
  always_comb begin
    unique case (sel)
      MX_BLUE:  hue_c = neg ? 9'd240 - qh - 9'(hrem != '0) : 9'd240 + qh;
      MX_GREEN: hue_c = neg ? 9'd120 - qh - 9'(hrem != '0) : 9'd120 + qh;
      MX_RED:   hue_c = neg ? ((qh == '0) ? 9'd0 : 9'd360 - qh) : qh;
      default:  hue_c = '0;
    endcase
    if (dz) hue_c = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (acc) state <= F_DIV;
        F_DIV:  if (hdone) state <= F_PUSH;
        F_PUSH: if (push_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ent.red         <= red;
      ent.green       <= green;
      ent.blue        <= blue;
      ent.block_index <= block_index;
      ent.first       <= first_in_block;
      ent.last        <= last_in_block;
      ent.val         <= v_c;
      sel             <= sel_c;
      neg             <= neg_c;
      dz              <= (d == '0);
      mz              <= (mx == '0);
    end
    if (state == F_DIV && hdone) begin
      ent.hue <= hue_c;
      ent.sat <= mz ? 7'd0 : sq[6:0];
    end
  end

  assign push_valid = (state == F_PUSH);
  assign push_data  = ent;

  // both dividers run in lockstep; sdone mirrors hdone
  logic unused_s;
  assign unused_s = sdone ^ (|srem) ^ (|sq[14:7]) ^ (|hq[14:9]);

endmodule

// ----- hw/rtl/bhcd_fifo.sv -----
module bhcd_fifo import bhcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  pix_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output pix_t pop_data,
  input  logic pop
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  pix_t          slots [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ----- hw/rtl/bhcd_back.sv -----
module bhcd_back import bhcd_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [BP_W-1:0] block_pixels,
  input  logic [CP_W-1:0] change_percent,
  input  logic            fifo_valid,
  input  pix_t            fifo_data,
  output logic            fifo_pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic            block_done,
  output logic [8:0]      avg_hue,
  output logic [6:0]      avg_sat,
  output logic [6:0]      avg_val,
  output logic            changed
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DW = 21;

  typedef struct packed {
    logic                 flag;
    logic [6:0]           pv;
    logic [SV_SUM_W-1:0]  vs;
    logic [SV_SUM_W-1:0]  ss;
    logic [HUE_SUM_W-1:0] hs;
  } ent_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_READ, B_ACC, B_DIVH, B_DIVS, B_DIVV, B_DIVC, B_OUT
  } bstate_t;

  bstate_t state;
  pix_t    item;
  ent_t    mem [MAX_BLOCKS];
  ent_t    rd;
  ent_t    wdata;
  logic    we;
  logic [AW-1:0] clr_cnt, item_addr, waddr;

  logic [HUE_SUM_W-1:0] hs_r, hs_new;
  logic [SV_SUM_W-1:0]  ss_r, ss_new, vs_r, vs_new;
  logic [6:0]           pv_r;
  logic                 in_range;
  logic [BP_W-1:0]      n_eff;

  logic          dstart, ddone;
  logic [DW-1:0] ddvd, dq;
  logic [BP_W-1:0] ddvs, drem;

  logic [6:0] av_c;
  logic [7:0] tot_c;
  logic [6:0] dif_c;
  logic       chg_c;

  assign item_addr = AW'(item.block_index);
  assign in_range  = ({23'd0, item.block_index} < 32'(MAX_BLOCKS));
  assign clearing  = (state == B_CLEAR);
  assign waddr     = clearing ? clr_cnt : item_addr;

  always_comb begin
    if (block_pixels == '0) n_eff = BP_W'(1);
    else if (32'(block_pixels) > MAX_BLOCK_PIXELS) n_eff = BP_W'(MAX_BLOCK_PIXELS);
    else n_eff = block_pixels;
  end

  assign hs_new = (item.first ? '0 : rd.hs) + HUE_SUM_W'(item.hue);
  assign ss_new = (item.first ? '0 : rd.ss) + SV_SUM_W'(item.sat);
  assign vs_new = (item.first ? '0 : rd.vs) + SV_SUM_W'(item.val);

  // value average and change test
  assign av_c  = (dq > DW'(100)) ? 7'd100 : dq[6:0];
  assign tot_c = 8'(pv_r) + 8'(av_c);
  assign dif_c = (pv_r > av_c) ? pv_r - av_c : av_c - pv_r;
  assign chg_c = dq > DW'(change_percent);

  bhcd_div #(.WN(DW), .WD(BP_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (dstart),
    .dividend  (ddvd),
    .divisor   (ddvs),
    .done      (ddone),
    .quotient  (dq),
    .remainder (drem)
  );

  always_comb begin
    fifo_pop = 1'b0;
    dstart   = 1'b0;
    ddvd     = '0;
    ddvs     = n_eff;
    we       = 1'b0;
    wdata    = '0;
    unique case (state)
      B_CLEAR: we = 1'b1;
      B_IDLE:  fifo_pop = fifo_valid;
      B_ACC: begin
        we    = in_range;
        wdata = '{flag: rd.flag, pv: rd.pv, vs: vs_new, ss: ss_new, hs: hs_new};
        if (in_range && item.last) begin
          dstart = 1'b1;
          ddvd   = DW'(hs_new);
        end
      end
      B_DIVH: if (ddone) begin
        dstart = 1'b1;
        ddvd   = DW'(ss_r);
      end
      B_DIVS: if (ddone) begin
        dstart = 1'b1;
        ddvd   = DW'(vs_r);
      end
      B_DIVV: if (ddone) begin
        if (tot_c != '0) begin
          dstart = 1'b1;
          ddvd   = DW'(15'(dif_c) * 15'd200);
          ddvs   = BP_W'(tot_c);
        end else begin
          we    = 1'b1;
          wdata = '{flag: 1'b0, pv: av_c, vs: vs_r, ss: ss_r, hs: hs_r};
        end
      end
      B_DIVC: if (ddone) begin
        we    = 1'b1;
        wdata = '{flag: chg_c, pv: avg_val, vs: vs_r, ss: ss_r, hs: hs_r};
      end
      B_READ, B_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[item_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_BLOCKS - 1)) state <= B_IDLE;
        end
        B_IDLE: if (fifo_valid) begin
          item  <= fifo_data;
          state <= B_READ;
        end
        B_READ: state <= B_ACC;
        B_ACC: begin
          hs_r       <= hs_new;
          ss_r       <= ss_new;
          vs_r       <= vs_new;
          pv_r       <= rd.pv;
          out_red    <= (in_range && rd.flag) ? MARK_RED   : item.red;
          out_green  <= (in_range && rd.flag) ? MARK_GREEN : item.green;
          out_blue   <= (in_range && rd.flag) ? MARK_BLUE  : item.blue;
          block_done <= 1'b0;
          avg_hue    <= '0;
          avg_sat    <= '0;
          avg_val    <= '0;
          changed    <= 1'b0;
          if (in_range && item.last) begin
            state <= B_DIVH;
          end else begin
            out_valid <= 1'b1;
            state     <= B_OUT;
          end
        end
        B_DIVH: if (ddone) begin
          avg_hue <= (dq > DW'(359)) ? 9'd359 : dq[8:0];
          state   <= B_DIVS;
        end
        B_DIVS: if (ddone) begin
          avg_sat <= (dq > DW'(100)) ? 7'd100 : dq[6:0];
          state   <= B_DIVV;
        end
        B_DIVV: if (ddone) begin
          avg_val    <= av_c;
          block_done <= 1'b1;
          if (tot_c != '0) begin
            state <= B_DIVC;
          end else begin
            out_valid <= 1'b1;
            state     <= B_OUT;
          end
        end
        B_DIVC: if (ddone) begin
          changed   <= chg_c;
          out_valid <= 1'b1;
          state     <= B_OUT;
        end
        B_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  logic unused_rem;
  assign unused_rem = |drem;

endmodule
